/* rtl/lms_pkg.sv */
// Shared types, sizes and helpers for the LED matrix row scanner.
// No dependencies; compiled before every other file of the block.

package lms_pkg;

    localparam int ROW_COUNT     = 16;
    localparam int BYTES_PER_ROW = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int STORE_DEPTH   = ROW_COUNT * BYTES_PER_ROW;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int BIT_W   = $clog2(BITS_PER_BYTE);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int DATA_W  = BITS_PER_BYTE;
    localparam int TICKS_W = 8;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = TICKS_W'(5);

    // Pin levels driven towards the column driver and row decoder
    typedef struct packed {
        logic             clk;
        logic             data;
        logic             latch;
        logic             blank;
        logic [ROW_W-1:0] addr;
        logic             inh;
        logic             stb;
    } t_pins;

    // Scan position: row and column byte
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_scan_pos;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(BYTES_PER_ROW);
        return base + ADDR_W'(col);
    endfunction

endpackage

/* rtl/lms_in_if.sv */
// Input channel of the LED matrix row scanner: valid/ready plus item fields.
// Depends on lms_pkg.

interface lms_in_if import lms_pkg::*;;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  byte_index;
    logic [DATA_W-1:0] pixel_byte;

    modport source (output valid, command, row_index, byte_index, pixel_byte,
                    input ready);
    modport sink   (input valid, command, row_index, byte_index, pixel_byte,
                    output ready);
endinterface

/* rtl/lms_out_if.sv */
// Result channel of the LED matrix row scanner: valid/ready plus pin levels.
// Depends on lms_pkg.

interface lms_out_if import lms_pkg::*;;
    logic             valid;
    logic             ready;
    logic             shift_clock;
    logic             shift_data;
    logic             latch_enable;
    logic             output_blank;
    logic [ROW_W-1:0] row_address;
    logic             row_inhibit;
    logic             row_strobe;

    modport source (output valid, shift_clock, shift_data, latch_enable, output_blank,
                    row_address, row_inhibit, row_strobe, input ready);
    modport sink   (input valid, shift_clock, shift_data, latch_enable, output_blank,
                    row_address, row_inhibit, row_strobe, output ready);
endinterface

/* rtl/led_matrix_row_scanner.sv */
// Top level of the LED matrix row scanner: config register, frame store,
// pin sequencer and result skid. Depends on lms_pkg, lms_in_if, lms_out_if.
// Usage:
//   i_in carries one item per transfer. command 1 writes pixel_byte into the
//   frame store at row_index/byte_index (out-of-frame writes are dropped);
//   command 0 is a tick that moves the pin sequencer on by one step.
//   Every input transfer yields exactly one result on o_out: the pin levels
//   after the item (a write reports the levels unchanged).
//   i_cfg_we/i_cfg_wdata set phase_ticks, the length in ticks of each clock,
//   blank and latch phase (0 counts as 1); write it only while idle.
// Result path and rate:
//   The result is registered on o_out, or held in the skid entry while o_out is
//   stalled. One item is taken every cycle while i_in.ready is high; the store
//   read for the next tick is issued on the same edge as the state update.
// Reset (i_rst_n low, synchronous): row 0, byte 9, bit 0, clock-low phase,
//   blank and inhibit high. Per-entry valid bits make the store read as zero
//   at once; no clearing pass, so items are taken from the first cycle.
// Stall:
//   A result register plus one skid entry hold results while o_out.ready is
//   low; i_in.ready drops only when both are full.

module led_matrix_row_scanner
    import lms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    lms_in_if.sink             i_in,
    lms_out_if.source          o_out
);

    logic [TICKS_W-1:0] r_phase_ticks;
    logic               accept;
    logic               wr_item;
    logic               tick_item;
    logic               skid_ready;
    logic [DATA_W-1:0]  cur_byte;
    t_scan_pos          next_pos;
    t_pins              next_pins;
    t_pins              pins;

    // Hold the phase length; the user must write it only while the block is idle (the block has no check for it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    assign i_in.ready = skid_ready;
    assign accept     = i_in.valid && skid_ready;
    assign wr_item    = accept && i_in.command;
    assign tick_item  = accept && !i_in.command;

    // Store read follows the sequencer's next scan position
    lms_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_item),
        .i_wr_row  (i_in.row_index),
        .i_wr_col  (i_in.byte_index),
        .i_wr_data (i_in.pixel_byte),
        .i_rd_pos  (next_pos),
        .o_rd_data (cur_byte)
    );

    // Advance one step per tick transfer
    lms_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick_item),
        .i_phase_ticks (r_phase_ticks),
        .i_cur_byte    (cur_byte),
        .o_next_pos    (next_pos),
        .o_next_pins   (next_pins),
        .o_pins        (pins)
    );

    // Push the post-item pin levels on every transfer
    lms_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_pins  (next_pins),
        .o_ready (skid_ready),
        .o_out   (o_out)
    );

    // Latch pulses only while the column outputs are blanked
    a_latch_blanked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pins.latch |-> pins.blank)
        else $error("latch high with outputs unblanked");

    // Rows are inhibited only inside the blanked window
    a_inhibit_blanked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pins.inh |-> pins.blank)
        else $error("row inhibit high with outputs unblanked");

    // A frame write leaves the pins untouched
    a_write_holds_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_item |=> $stable(pins))
        else $error("pin levels moved on a frame write");

endmodule

/* rtl/lms_frame_store.sv */
// Frame store: one byte per row and column byte, with per-entry valid bits.
// Depends on lms_pkg. Read data is registered, write-first on a collision.

module lms_frame_store
    import lms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ROW_W-1:0]  i_wr_row,
    input  logic [COL_W-1:0]  i_wr_col,
    input  logic [DATA_W-1:0] i_wr_data,
    input  t_scan_pos         i_rd_pos,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [STORE_DEPTH];
    logic              r_valid [STORE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              wr_hit;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Drop writes outside the frame
    assign wr_hit  = i_wr_en && (int'(i_wr_row) < ROW_COUNT)
                             && (int'(i_wr_col) < BYTES_PER_ROW);
    assign wr_addr = store_addr(i_wr_row, i_wr_col);
    assign rd_addr = store_addr(i_rd_pos.row, i_rd_pos.col);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit && (wr_addr == rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_vld <= (wr_hit && (wr_addr == rd_addr)) || r_valid[rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/lms_sequencer.sv */
// Pin sequencer: one step per tick through shift, blank, latch, row-select, unblank.
// Depends on lms_pkg. Byte at the current scan position comes from the store.

module lms_sequencer
    import lms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [TICKS_W-1:0] i_phase_ticks,
    input  logic [DATA_W-1:0]  i_cur_byte,
    output t_scan_pos          o_next_pos,
    output t_pins              o_next_pins,
    output t_pins              o_pins
);

    localparam logic [2:0] PH_CLK_LOW  = 3'd0;
    localparam logic [2:0] PH_CLK_HIGH = 3'd1;
    localparam logic [2:0] PH_BLANK    = 3'd2;
    localparam logic [2:0] PH_LATCH_HI = 3'd3;
    localparam logic [2:0] PH_LATCH_LO = 3'd4;
    localparam logic [2:0] PH_ROW_SEL  = 3'd5;
    localparam logic [2:0] PH_UNBLANK  = 3'd6;

    logic [ROW_W-1:0]   r_row,   n_row;
    logic [COL_W-1:0]   r_col,   n_col;
    logic [BIT_W-1:0]   r_bit_pos, n_bit_pos;
    logic [2:0]         r_phase, n_phase;
    logic [TICKS_W-1:0] r_count, n_count;
    t_pins              r_pins,  n_pins;

    logic [2:0]         ph;
    logic [TICKS_W-1:0] cnt;
    logic [TICKS_W-1:0] dur;

    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_bit_pos = r_bit_pos;
        n_phase   = r_phase;
        n_count   = r_count;
        n_pins    = r_pins;
        ph        = r_phase;
        cnt       = r_count;
        dur       = (i_phase_ticks == '0) ? TICKS_W'(1) : i_phase_ticks;
        if (i_tick) begin
            // Restart on a code outside the phase list
            if (r_phase > PH_UNBLANK) begin
                ph  = PH_CLK_LOW;
                cnt = '0;
            end
            if (cnt == '0) begin
                case (ph)
                    PH_CLK_LOW: begin
                        n_pins.clk  = 1'b0;
                        n_pins.data = i_cur_byte[r_bit_pos];
                    end
                    PH_CLK_HIGH: begin
                        n_pins.clk = 1'b1;
                    end
                    PH_BLANK: begin
                        n_pins.blank = 1'b1;
                    end
                    PH_LATCH_HI: begin
                        n_pins.latch = 1'b1;
                    end
                    PH_LATCH_LO: begin
                        n_pins.latch = 1'b0;
                    end
                    PH_ROW_SEL: begin
                        n_pins.addr = r_row;
                        n_pins.stb  = 1'b1;
                        n_pins.inh  = 1'b1;
                        dur         = TICKS_W'(1);
                    end
                    default: begin
                        n_pins.inh   = 1'b0;
                        n_pins.blank = 1'b0;
                    end
                endcase
                cnt = dur;
            end
            cnt     = cnt - TICKS_W'(1);
            n_count = cnt;
            n_phase = ph;
            if (cnt == '0) begin
                case (ph)
                    PH_CLK_LOW: begin
                        n_phase = PH_CLK_HIGH;
                    end
                    PH_CLK_HIGH: begin
                        if (r_bit_pos != BIT_W'(BITS_PER_BYTE - 1)) begin
                            n_bit_pos = r_bit_pos + BIT_W'(1);
                            n_phase   = PH_CLK_LOW;
                        end else begin
                            n_bit_pos = '0;
                            if (r_col != '0) begin
                                n_col   = r_col - COL_W'(1);
                                n_phase = PH_CLK_LOW;
                            end else begin
                                n_phase = PH_BLANK;
                            end
                        end
                    end
                    PH_BLANK: begin
                        n_phase = PH_LATCH_HI;
                    end
                    PH_LATCH_HI: begin
                        n_phase = PH_LATCH_LO;
                    end
                    PH_LATCH_LO: begin
                        n_phase = PH_ROW_SEL;
                    end
                    PH_ROW_SEL: begin
                        n_phase = PH_UNBLANK;
                    end
                    default: begin
                        n_col     = COL_W'(BYTES_PER_ROW - 1);
                        n_bit_pos = '0;
                        n_row     = (r_row == ROW_W'(ROW_COUNT - 1)) ? '0
                                                                   : r_row + ROW_W'(1);
                        n_phase   = PH_CLK_LOW;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= COL_W'(BYTES_PER_ROW - 1);
            r_bit_pos <= '0;
            r_phase   <= PH_CLK_LOW;
            r_count   <= '0;
            r_pins    <= '{clk: 1'b0, data: 1'b0, latch: 1'b0, blank: 1'b1,
                           addr: '0, inh: 1'b1, stb: 1'b0};
        end else begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_bit_pos <= n_bit_pos;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_pins    <= n_pins;
        end
    end

    assign o_next_pos  = '{row: n_row, col: n_col};
    assign o_next_pins = n_pins;
    assign o_pins      = r_pins;

endmodule

/* rtl/lms_out_skid.sv */
// Result register with a skid stage, so the input side keeps moving on a stall.
// Depends on lms_pkg and lms_out_if.

module lms_out_skid
    import lms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_pins       i_pins,
    output logic        o_ready,
    lms_out_if.source   o_out
);

    logic  r_out_vld;
    logic  r_skid_vld;
    t_pins r_out;
    t_pins r_skid;
    logic  take;

    assign take    = r_out_vld && o_out.ready;
    assign o_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take || !r_out_vld) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= i_push;
                end
            end else if (i_push) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_pins;
            end
        end else if (i_push) begin
            r_skid <= i_pins;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.shift_clock  = r_out.clk;
    assign o_out.shift_data   = r_out.data;
    assign o_out.latch_enable = r_out.latch;
    assign o_out.output_blank = r_out.blank;
    assign o_out.row_address  = r_out.addr;
    assign o_out.row_inhibit  = r_out.inh;
    assign o_out.row_strobe   = r_out.stb;

endmodule

/* tb/sv/lms_scan_checker.sv */
// Scoreboard for the LED matrix row scanner: predicts the pin levels for every
// input transfer and compares them with each result transfer, in order.
// Depends on lms_pkg, lms_in_if and lms_out_if; holds the item command codes.

package lms_tb_pkg;
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
endpackage

module lms_scan_checker
    import lms_pkg::*;
    import lms_tb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    lms_in_if                  i_in_mon,
    lms_out_if                 i_out_mon,
    output int                 o_pending,
    output int                 o_mismatches
);

    typedef enum logic [2:0] {
        SCAN_CLK_LOW,
        SCAN_CLK_HIGH,
        SCAN_BLANK,
        SCAN_LATCH_HIGH,
        SCAN_LATCH_LOW,
        SCAN_ROW_SELECT,
        SCAN_UNBLANK
    } t_scan_phase;

    // Predicted block state
    logic [DATA_W-1:0]  frame [STORE_DEPTH];
    logic [ROW_W-1:0]   scan_row;
    logic [COL_W-1:0]   byte_pos;
    logic [BIT_W-1:0]   bit_pos;
    t_scan_phase        phase;
    logic [TICKS_W-1:0] countdown;
    logic [TICKS_W-1:0] phase_ticks;
    t_pins              pins;

    t_pins expected_pins [$];
    int    pending_count = 0;
    int    mismatches    = 0;
    int    result_count  = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, result_count, got, want);
    endtask

    task automatic clear_scan();
        foreach (frame[i])
            frame[i] = '0;
        scan_row    = '0;
        byte_pos    = COL_W'(BYTES_PER_ROW - 1);
        bit_pos     = '0;
        phase       = SCAN_CLK_LOW;
        countdown   = '0;
        phase_ticks = PHASE_TICKS_RST;
        pins        = '0;
        pins.blank  = 1'b1;
        pins.inh    = 1'b1;
    endtask

    // Pin changes land on the first tick of a phase
    task automatic enter_phase();
        logic [TICKS_W-1:0] dur;
        logic [DATA_W-1:0]  col_byte;
        dur = (phase_ticks == '0) ? TICKS_W'(1) : phase_ticks;
        case (phase)
            SCAN_CLK_LOW: begin
                col_byte  = frame[int'(scan_row) * BYTES_PER_ROW + int'(byte_pos)];
                pins.clk  = 1'b0;
                pins.data = col_byte[bit_pos];
            end
            SCAN_CLK_HIGH:   pins.clk   = 1'b1;
            SCAN_BLANK:      pins.blank = 1'b1;
            SCAN_LATCH_HIGH: pins.latch = 1'b1;
            SCAN_LATCH_LOW:  pins.latch = 1'b0;
            SCAN_ROW_SELECT: begin
                pins.addr = scan_row;
                pins.stb  = 1'b1;
                pins.inh  = 1'b1;
                dur       = TICKS_W'(1);
            end
            default: begin
                pins.inh   = 1'b0;
                pins.blank = 1'b0;
            end
        endcase
        countdown = dur;
    endtask

    task automatic leave_phase();
        case (phase)
            SCAN_CLK_LOW: phase = SCAN_CLK_HIGH;
            SCAN_CLK_HIGH: begin
                if (int'(bit_pos) < BITS_PER_BYTE - 1) begin
                    bit_pos++;
                    phase = SCAN_CLK_LOW;
                end else begin
                    bit_pos = '0;
                    if (byte_pos != '0) begin
                        byte_pos--;
                        phase = SCAN_CLK_LOW;
                    end else begin
                        phase = SCAN_BLANK;
                    end
                end
            end
            SCAN_BLANK:      phase = SCAN_LATCH_HIGH;
            SCAN_LATCH_HIGH: phase = SCAN_LATCH_LOW;
            SCAN_LATCH_LOW:  phase = SCAN_ROW_SELECT;
            SCAN_ROW_SELECT: phase = SCAN_UNBLANK;
            default: begin
                byte_pos = COL_W'(BYTES_PER_ROW - 1);
                bit_pos  = '0;
                scan_row = (int'(scan_row) == ROW_COUNT - 1) ? '0 : scan_row + 1'b1;
                phase    = SCAN_CLK_LOW;
            end
        endcase
    endtask

    task automatic advance_scan();
        if (countdown == '0)
            enter_phase();
        countdown--;
        if (countdown == '0)
            leave_phase();
    endtask

    initial clear_scan();

    always @(posedge i_clk) begin : watch
        t_pins seen;
        t_pins want;
        if (!i_rst_n) begin
            clear_scan();
            expected_pins.delete();
        end else begin
            if (i_cfg_we)
                phase_ticks = i_cfg_wdata;

            if (i_out_mon.valid && i_out_mon.ready) begin
                seen.clk   = i_out_mon.shift_clock;
                seen.data  = i_out_mon.shift_data;
                seen.latch = i_out_mon.latch_enable;
                seen.blank = i_out_mon.output_blank;
                seen.addr  = i_out_mon.row_address;
                seen.inh   = i_out_mon.row_inhibit;
                seen.stb   = i_out_mon.row_strobe;
                if (expected_pins.size() == 0) begin
                    report_mismatch("unexpected result", int'(seen), 0);
                end else begin
                    want = expected_pins.pop_front();
                    if (seen.clk !== want.clk)
                        report_mismatch("shift_clock", seen.clk, want.clk);
                    if (seen.data !== want.data)
                        report_mismatch("shift_data", seen.data, want.data);
                    if (seen.latch !== want.latch)
                        report_mismatch("latch_enable", seen.latch, want.latch);
                    if (seen.blank !== want.blank)
                        report_mismatch("output_blank", seen.blank, want.blank);
                    if (seen.addr !== want.addr)
                        report_mismatch("row_address", seen.addr, want.addr);
                    if (seen.inh !== want.inh)
                        report_mismatch("row_inhibit", seen.inh, want.inh);
                    if (seen.stb !== want.stb)
                        report_mismatch("row_strobe", seen.stb, want.stb);
                end
                result_count++;
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.command == CMD_WRITE) begin
                    if (int'(i_in_mon.row_index) < ROW_COUNT &&
                        int'(i_in_mon.byte_index) < BYTES_PER_ROW)
                        frame[int'(i_in_mon.row_index) * BYTES_PER_ROW +
                              int'(i_in_mon.byte_index)] = i_in_mon.pixel_byte;
                end else begin
                    advance_scan();
                end
                expected_pins.push_back(pins);
            end
        end
        pending_count = expected_pins.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the LED matrix row scanner bench: clock, reset, stimulus and verdict.
// Depends on lms_pkg, lms_in_if, lms_out_if, lms_tb_pkg and lms_scan_checker.

module tb_top
    import lms_pkg::*;
    import lms_tb_pkg::*;
();

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 2;   // wait after the last result before the register write
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int STALL_LIMIT     = 2000;
    // Random items over all phases; the phase with one-tick phases runs
    // several rows deep (165 ticks per row).
    localparam int RANDOM_TOTAL    = 1530;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [TICKS_W-1:0] cfg_wdata;

    lms_in_if  scan_in ();
    lms_out_if scan_out ();

    int pending_results;
    int mismatches;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int random_sent   = 0;
    bit hold_request  = 1'b0;

    led_matrix_row_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (scan_in),
        .o_out       (scan_out)
    );

    lms_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (scan_in),
        .i_out_mon    (scan_out),
        .o_pending    (pending_results),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Offer one item, idling first at the current rate, and hold it until the
    // transfer. Keep valid high straight into the next item when no gap falls.
    task automatic send_item(input logic cmd, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [DATA_W-1:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            scan_in.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        scan_in.valid      <= 1'b1;
        scan_in.command    <= cmd;
        scan_in.row_index  <= row;
        scan_in.byte_index <= col;
        scan_in.pixel_byte <= pix;
        do @(posedge i_clk); while (!(scan_in.valid && scan_in.ready));
    endtask

    // Mostly ticks, so the sequencer gets deep; writes keep refreshing the
    // frame, with the odd one aimed past the last column byte.
    task automatic send_random(input int tick_pct);
        logic [COL_W-1:0] col;
        if ($urandom_range(99) < tick_pct) begin
            send_item(CMD_TICK, ROW_W'($urandom), COL_W'($urandom), DATA_W'($urandom));
        end else begin
            if ($urandom_range(19) == 0)
                col = COL_W'($urandom_range(15, BYTES_PER_ROW));
            else
                col = COL_W'($urandom_range(BYTES_PER_ROW - 1));
            send_item(CMD_WRITE, ROW_W'($urandom), col, DATA_W'($urandom));
        end
    endtask

    // Drop valid, wait for every outstanding result, then write the register.
    task automatic set_phase_ticks(input logic [TICKS_W-1:0] value);
        scan_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int tick_pct);
        repeat (count) begin
            // Receiver-heavy idling, then sender-heavy, then none at all
            if (random_sent < RANDOM_TOTAL / 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 67;
            end else if (random_sent < 2 * RANDOM_TOTAL / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Hold the receiver off now and then so the skid fills and the
            // input stalls while items keep coming
            if (random_sent == 300 || random_sent == 800 || random_sent == 1400)
                hold_request = 1'b1;
            send_random(tick_pct);
            random_sent++;
        end
    endtask

    // Result side: random back-pressure, or a long hold-off on request
    initial begin
        scan_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                scan_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                scan_out.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((scan_in.valid && scan_in.ready) || (scan_out.valid && scan_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("led_matrix_row_scanner test failed");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        scan_in.valid      <= 1'b0;
        scan_in.command    <= CMD_TICK;
        scan_in.row_index  <= '0;
        scan_in.byte_index <= '0;
        scan_in.pixel_byte <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: frame corners and the first bytes shifted, extreme pixel
        // values, writes outside the frame, then ticks at the reset length
        send_item(CMD_WRITE, 4'd0, 4'd9, 8'hA5);
        send_item(CMD_WRITE, 4'd0, 4'd8, 8'hFF);
        send_item(CMD_WRITE, 4'd0, 4'd0, 8'h81);
        send_item(CMD_WRITE, 4'd15, 4'd9, 8'h80);
        send_item(CMD_WRITE, 4'd15, 4'd0, 8'hFF);
        send_item(CMD_WRITE, 4'd1, 4'd9, 8'h00);
        send_item(CMD_WRITE, 4'd0, 4'd10, 8'h3C);   // byte past the row: drop
        send_item(CMD_WRITE, 4'd15, 4'd15, 8'hFF);  // likewise
        repeat (7) send_item(CMD_TICK, 4'd0, 4'd0, 8'h00);
        repeat (7) send_item(CMD_TICK, 4'd15, 4'd15, 8'hFF);

        run_phase(150, 80);
        set_phase_ticks(TICKS_W'(1));
        run_phase(980, 98);
        set_phase_ticks(TICKS_W'(0));    // zero counts as one tick
        run_phase(100, 85);
        set_phase_ticks(TICKS_W'(255));
        run_phase(100, 90);
        set_phase_ticks(TICKS_W'(2));
        run_phase(100, 85);
        set_phase_ticks(TICKS_W'($urandom_range(254, 3)));
        run_phase(100, 85);

        // Drain the result side, let the block settle, then give the verdict
        scan_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results == 0)
            $display("led_matrix_row_scanner test passed");
        else
            $display("led_matrix_row_scanner test failed");
        $finish;
    end

endmodule
